FILE: rtl/fixed_point_alu_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point ALU unit.
// Shared property shapes so every asserting file writes its checks the same way.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Transaction types, opcodes and saturation limits shared by the ALU modules.
// ----------------------------------------------------------------------------
package fpa_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_INC = 3'd4,
		OP_DEC = 3'd5,
		OP_MIN = 3'd6,
		OP_MAX = 3'd7
	} fpa_op_t;

	localparam logic signed [31:0] RAW_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] RAW_MIN = 32'sh8000_0000;

	typedef struct packed {
		fpa_op_t            opcode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} fpa_in_t;

	typedef struct packed {
		logic signed [31:0] result_raw;
		logic               a_less;
		logic               a_greater;
		logic               a_equal;
		logic signed [23:0] a_integer_part;
		logic               overflow;
		logic               divide_by_zero;
	} fpa_out_t;

	// Contents of one divider cell. nq holds the numerator bits still to be
	// consumed at the top and the quotient bits produced so far at the bottom.
	typedef struct packed {
		logic        valid;
		logic        div_go;
		logic        neg;
		logic [31:0] rem;
		logic [31:0] dvsr;
		logic [31:0] nq;
		fpa_out_t    info;
	} fpa_cell_t;

endpackage

FILE: rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Two stages: operand magnitudes and flags, then multiply, add and divide setup.
// ----------------------------------------------------------------------------
module fpa_front #(
	parameter int FRACTION_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              req_valid,
	input  fpa_pkg::fpa_in_t  req,
	output fpa_pkg::fpa_cell_t entry
);
	import fpa_pkg::*;

	localparam int NW = 32 + FRACTION_BITS;

	logic               v_s1;
	fpa_op_t            op_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;
	logic [31:0]        maga_s1;
	logic [31:0]        magb_s1;
	fpa_out_t           info_s1;

	logic               v_s2;
	logic               mul_s2;
	logic               neg_s2;
	logic               div_go_s2;
	logic [63:0]        prod_s2;
	logic [31:0]        rem_s2;
	logic [31:0]        nq_s2;
	logic [31:0]        dvsr_s2;
	fpa_out_t           info_s2;

	logic signed [31:0] shr;
	fpa_out_t           info_n;
	logic               neg_n;
	logic               div_go_n;
	logic signed [32:0] addend;
	logic signed [32:0] sum;
	logic [NW-1:0]      num;
	logic [31:0]        nhi;
	logic [63:0]        pq;

	// First stage: compare flags and integer part come straight from the operands.
	assign shr = $signed(req.operand_a) >>> FRACTION_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			op_s1 <= req.opcode;
			a_s1 <= req.operand_a;
			b_s1 <= req.operand_b;
			maga_s1 <= req.operand_a[31] ? 32'(-req.operand_a) : req.operand_a;
			magb_s1 <= req.operand_b[31] ? 32'(-req.operand_b) : req.operand_b;
			info_s1.result_raw <= '0;
			info_s1.a_less <= $signed(req.operand_a) < $signed(req.operand_b);
			info_s1.a_greater <= $signed(req.operand_a) > $signed(req.operand_b);
			info_s1.a_equal <= req.operand_a == req.operand_b;
			info_s1.a_integer_part <= shr[23:0];
			info_s1.overflow <= 1'b0;
			info_s1.divide_by_zero <= 1'b0;
		end
	end

	// Second stage: everything except the multiply rounding and the division.
	always_comb begin
		info_n = info_s1;
		neg_n = a_s1[31] ^ b_s1[31];
		div_go_n = 1'b0;
		num = {maga_s1, {FRACTION_BITS{1'b0}}};
		nhi = 32'(num >> 32);
		if (op_s1 == OP_ADD || op_s1 == OP_SUB) begin
			addend = {b_s1[31], b_s1};
		end else begin
			addend = 33'sd1;
		end
		if (op_s1 == OP_SUB || op_s1 == OP_DEC) begin
			sum = {a_s1[31], a_s1} - addend;
		end else begin
			sum = {a_s1[31], a_s1} + addend;
		end
		case (op_s1)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				if (sum[32] != sum[31]) begin
					info_n.overflow = 1'b1;
					info_n.result_raw = sum[32] ? RAW_MIN : RAW_MAX;
				end else begin
					info_n.result_raw = sum[31:0];
				end
			end
			OP_DIV: begin
				if (magb_s1 == 32'd0) begin
					info_n.divide_by_zero = 1'b1;
					info_n.result_raw = a_s1[31] ? RAW_MIN : RAW_MAX;
				end else if (nhi >= magb_s1) begin
					// Quotient reaches 2^32: saturated before any division step.
					info_n.overflow = 1'b1;
					info_n.result_raw = neg_n ? RAW_MIN : RAW_MAX;
				end else begin
					div_go_n = 1'b1;
				end
			end
			OP_MIN: info_n.result_raw = info_s1.a_less ? a_s1 : b_s1;
			OP_MAX: info_n.result_raw = info_s1.a_greater ? a_s1 : b_s1;
			default: info_n.result_raw = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			mul_s2 <= op_s1 == OP_MUL;
			neg_s2 <= neg_n;
			div_go_s2 <= div_go_n;
			prod_s2 <= maga_s1 * magb_s1;
			rem_s2 <= nhi;
			nq_s2 <= num[31:0];
			dvsr_s2 <= magb_s1;
			info_s2 <= info_n;
		end
	end

	// Multiply rounding and saturation feed the first divider cell.
	always_comb begin
		pq = (prod_s2 + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		entry.valid = v_s2;
		entry.div_go = div_go_s2;
		entry.neg = neg_s2;
		entry.rem = rem_s2;
		entry.dvsr = dvsr_s2;
		entry.nq = nq_s2;
		entry.info = info_s2;
		if (mul_s2) begin
			if (neg_s2) begin
				if (pq > 64'h8000_0000) begin
					entry.info.overflow = 1'b1;
					entry.info.result_raw = RAW_MIN;
				end else begin
					entry.info.result_raw = -pq[31:0];
				end
			end else if (pq > 64'h7FFF_FFFF) begin
				entry.info.overflow = 1'b1;
				entry.info.result_raw = RAW_MAX;
			end else begin
				entry.info.result_raw = pq[31:0];
			end
		end
	end

endmodule

FILE: rtl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring division step per cell, registered, with the transaction riding along.
// ----------------------------------------------------------------------------
module fpa_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  fpa_pkg::fpa_cell_t c_in,
	output fpa_pkg::fpa_cell_t c_out
);
	import fpa_pkg::*;

	fpa_cell_t  cell_q;
	fpa_cell_t  nxt;
	logic [32:0] trial;
	logic        ge;

	always_comb begin
		trial = {c_in.rem, c_in.nq[31]};
		ge = trial >= {1'b0, c_in.dvsr};
		nxt = c_in;
		nxt.rem = ge ? 32'(trial - {1'b0, c_in.dvsr}) : trial[31:0];
		nxt.nq = {c_in.nq[30:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q.valid <= 1'b0;
		end else if (adv) begin
			cell_q <= nxt;
		end
	end

	assign c_out = cell_q;

endmodule

FILE: rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Division rounding and saturation, then the result register with a skid entry.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_unit_macros.svh"

module fpa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fpa_pkg::fpa_cell_t last,
	output logic               adv,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output fpa_pkg::fpa_out_t  rsp
);
	import fpa_pkg::*;

	logic        rsp_valid_q;
	fpa_out_t    rsp_q;
	logic        skid_valid_q;
	fpa_out_t    skid_q;
	fpa_out_t    fin;
	logic [32:0] qr;
	logic        rnd;
	logic        ready_out;

	// Round half away from zero on the magnitude, then apply the sign and clamp.
	always_comb begin
		rnd = {last.rem, 1'b0} >= {1'b0, last.dvsr};
		qr = {1'b0, last.nq} + {32'd0, rnd};
		fin = last.info;
		if (last.div_go) begin
			if (last.neg) begin
				if (qr > 33'h0_8000_0000) begin
					fin.overflow = 1'b1;
					fin.result_raw = RAW_MIN;
				end else begin
					fin.result_raw = -qr[31:0];
				end
			end else if (qr > 33'h0_7FFF_FFFF) begin
				fin.overflow = 1'b1;
				fin.result_raw = RAW_MAX;
			end else begin
				fin.result_raw = qr[31:0];
			end
		end
	end

	assign ready_out = !rsp_valid_q || !rsp_stall;
	assign adv = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (ready_out) begin
			if (skid_valid_q) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= skid_q;
				skid_valid_q <= 1'b0;
			end else begin
				rsp_valid_q <= last.valid;
				rsp_q <= fin;
			end
		end else if (last.valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
			skid_q <= fin;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`FPA_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_valid_q, rsp_valid_q, "skid holds data with empty output register")
	`FPA_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && !rsp_stall, !skid_valid_q, "skid entry did not drain")

endmodule

FILE: rtl/fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU unit
// Signed Q fixed-point add, subtract, multiply, divide, step, min and max.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  fpa_in_t  (opcode, operand_a, operand_b)
//   rsp      out        rsp_valid/rsp_stall  fpa_out_t (result and flags)
//
// Every transaction passes through two front stages, a row of 32 divider cells that
// each resolve one quotient bit, and the result register. A new transaction is
// accepted every cycle while req_stall is low.
// Reset clears only the valid bits of the stages, the skid entry and the output.
// When the response is stalled, one more result lands in a skid entry, after which
// the whole pipeline holds and req_stall is raised until the skid entry drains.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_unit_macros.svh"

module fixed_point_alu_unit #(
	parameter int FRACTION_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  fpa_pkg::fpa_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output fpa_pkg::fpa_out_t rsp
);
	import fpa_pkg::*;

	localparam int NCELLS = 32;

	// One shared advance enable: the whole row moves unless the skid entry is full.
	logic      adv;
	fpa_cell_t chain [0:NCELLS];

	// The front end computes every operation except division, and prepares the
	// divider operands: magnitudes, the upper numerator bits as the starting
	// remainder, and an early saturation check for quotients of 2^32 and up.
	fpa_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.req_valid(req_valid),
		.req      (req),
		.entry    (chain[0])
	);

	// Every transaction walks the full row, so the latency is the same for all
	// opcodes and results leave in the order they arrived.
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.c_in  (chain[i]),
			.c_out (chain[i+1])
		);
	end

	// The back end rounds and clamps the quotient and owns the output handshake.
	fpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.last     (chain[NCELLS]),
		.adv      (adv),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	assign req_stall = !adv;

	`FPA_ASSERT_IMP(a_dz_no_ovf, clk, arst_n, rsp_valid && rsp.divide_by_zero, !rsp.overflow, "divide by zero reported with overflow")
	`FPA_ASSERT_IMP(a_ovf_saturated, clk, arst_n, rsp_valid && rsp.overflow, rsp.result_raw == RAW_MAX || rsp.result_raw == RAW_MIN, "overflow without a saturated result")
	`FPA_ASSERT_IMP(a_stall_cause, clk, arst_n, $rose(req_stall), $past(rsp_valid && rsp_stall), "input stall raised without a stalled response")

endmodule
